@@ src/iol_pkg.sv @@
// Shared types and constants for the indexed ordered list core.
// No dependencies; compiled first.
package iol_pkg;

	localparam int OP_W         = 3;
	localparam int POS_W        = 9;
	localparam int VAL_W        = 32;
	localparam int STAT_W       = 2;
	localparam int DEF_CAPACITY = 256;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_READ   = 3'd2,
		OP_FIND   = 3'd3,
		OP_LBOUND = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_TREE,
		S_DONE
	} state_t;

	// request as broadcast to every cell, plus checks done at accept time
	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] item_value;
		logic [POS_W-1:0]        count_lo;
		logic                    rng_ok;
		logic                    do_ins;
		logic                    do_del;
	} req_t;

endpackage

@@ src/iol_channels.sv @@
// Valid/ready channel interfaces for request and response beats.
// Depends on iol_pkg for field widths.
interface iol_req_if import iol_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         op;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] item_value;

	modport source (output valid, output op, output position, output item_value, input ready);
	modport sink   (input valid, input op, input position, input item_value, output ready);
endinterface

interface iol_rsp_if import iol_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic signed [VAL_W-1:0] found_value;
	logic [POS_W-1:0]        found_index;
	logic [POS_W-1:0]        entry_count;

	modport source (output valid, output status, output found_value, output found_index,
		output entry_count, input ready);
	modport sink   (input valid, input status, input found_value, input found_index,
		input entry_count, output ready);
endinterface

@@ src/iol_cell.sv @@
// One list slot: holds an entry, shifts with its neighbors, flags a hit.
// Depends on iol_pkg.
module iol_cell import iol_pkg::*; #(
	parameter int IDX   = 0,
	parameter int CNT_W = 9
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  req_t                    req,
	input  logic [CNT_W-1:0]        count,
	input  logic                    eval,
	input  logic signed [VAL_W-1:0] left_word,
	input  logic signed [VAL_W-1:0] right_word,
	output logic signed [VAL_W-1:0] word,
	output logic                    hit_s1,
	output logic signed [VAL_W-1:0] data_s1
);

	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

	logic signed [VAL_W-1:0] word_q;
	logic [CMP_W-1:0]        pos_x;
	logic [CMP_W-1:0]        cnt_x;
	logic                    below_cnt;
	logic                    hit;
	logic signed [VAL_W-1:0] word_nxt;

	assign pos_x     = CMP_W'(req.position);
	assign cnt_x     = CMP_W'(count);
	assign below_cnt = MY_IDX < cnt_x;
	assign word      = word_q;

	always_comb begin
		case (op_t'(req.op))
			OP_DELETE, OP_READ: hit = (MY_IDX == pos_x);
			OP_FIND:            hit = below_cnt && (word_q == req.item_value);
			OP_LBOUND:          hit = below_cnt && !(word_q < req.item_value);
			default:            hit = 1'b0;
		endcase
	end

	always_comb begin
		word_nxt = word_q;
		if (req.do_ins) begin
			if (MY_IDX == pos_x)
				word_nxt = req.item_value;
			else if (MY_IDX > pos_x)
				word_nxt = left_word;
		end else if (req.do_del) begin
			if (MY_IDX >= pos_x)
				word_nxt = right_word;
		end
	end

	always_ff @(posedge clk) begin
		if (eval) begin
			word_q  <= word_nxt;
			data_s1 <= word_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else if (eval) begin
			hit_s1 <= hit;
		end
	end

endmodule

@@ src/iol_tree.sv @@
// Registered first-hit tree: returns lowest index with a hit and its data.
// Depends on iol_pkg.
module iol_tree import iol_pkg::*; #(
	parameter int LEAVES = 256,
	parameter int IDX_W  = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    leaf_hit  [LEAVES],
	input  logic signed [VAL_W-1:0] leaf_data [LEAVES],
	output logic                    root_hit,
	output logic [IDX_W-1:0]        root_idx,
	output logic signed [VAL_W-1:0] root_data
);

	localparam int LEVELS = $clog2(LEAVES);
	localparam int N      = 1 << LEVELS;

	// heap order: node n has children 2n (lower indexes) and 2n+1
	logic                    node_hit_q  [1:2*N-1];
	logic [IDX_W-1:0]        node_idx_q  [1:2*N-1];
	logic signed [VAL_W-1:0] node_data_q [1:2*N-1];

	for (genvar i = 0; i < N; i++) begin : g_leaf
		if (i < LEAVES) begin : g_real
			assign node_hit_q[N+i]  = leaf_hit[i];
			assign node_data_q[N+i] = leaf_data[i];
		end else begin : g_pad
			assign node_hit_q[N+i]  = 1'b0;
			assign node_data_q[N+i] = '0;
		end
		assign node_idx_q[N+i] = IDX_W'(i);
	end

	for (genvar n = 1; n < N; n++) begin : g_node
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				node_hit_q[n] <= 1'b0;
			end else begin
				node_hit_q[n] <= node_hit_q[2*n] || node_hit_q[2*n+1];
			end
		end

		always_ff @(posedge clk) begin
			if (node_hit_q[2*n]) begin
				node_idx_q[n]  <= node_idx_q[2*n];
				node_data_q[n] <= node_data_q[2*n];
			end else begin
				node_idx_q[n]  <= node_idx_q[2*n+1];
				node_data_q[n] <= node_data_q[2*n+1];
			end
		end
	end

	assign root_hit  = node_hit_q[1];
	assign root_idx  = node_idx_q[1];
	assign root_data = node_data_q[1];

endmodule

@@ src/indexed_ordered_list_core.sv @@
// Indexed ordered list core: top level with control sequencer and cell chain.
// Depends on iol_pkg, iol_channels, iol_cell, iol_tree.
//
// A list of up to CAPACITY signed 32-bit words, addressed by position and
// empty after reset. Each request beat (insert, delete, read, find value,
// sorted position) produces exactly one response beat with status, value,
// index and the entry count after the request. Every entry lives in its own
// cell; on insert or delete all cells shift in the same cycle, and every cell
// compares its word against the request at once. The per-cell hit flags are
// then reduced by a registered first-hit tree of log2(CAPACITY) levels, one
// level per cycle. The response beat is presented once the request has passed
// the evaluate state, the tree levels and the load of the output register,
// and the core then returns to idle, ready for the next request; while the
// sink keeps up, the tree depth sets how long one request takes. A new
// request is taken once the previous response has been loaded into the
// output register, even if that beat is still waiting for the sink; a sink
// stall only costs cycles when the held beat is still there once the next
// result is ready. There is no clearing pass: slots at or past the count
// are never reported.
module indexed_ordered_list_core import iol_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	iol_req_if.sink     req,
	iol_rsp_if.source   rsp
);

	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int XW     = CNT_W + POS_W;
	localparam int LEVELS = IDX_W;
	localparam int TC_W   = $clog2(LEVELS + 1);

	state_t state_q, state_nxt;

	req_t                    req_q;
	req_t                    req_new;
	logic [CNT_W-1:0]        count_q;
	logic [TC_W-1:0]         tree_cnt_q;
	logic                    accept;
	logic                    eval;
	logic                    load_out;

	logic [CMP_W-1:0]        pos_x;
	logic [CMP_W-1:0]        cnt_x;
	logic [XW-1:0]           cnt_wide;
	logic [XW-1:0]           idx_wide;

	logic signed [VAL_W-1:0] cell_word [CAPACITY];
	logic                    leaf_hit  [CAPACITY];
	logic signed [VAL_W-1:0] leaf_data [CAPACITY];
	logic                    root_hit;
	logic [IDX_W-1:0]        root_idx;
	logic signed [VAL_W-1:0] root_data;

	logic                    rsp_valid_q;
	logic [STAT_W-1:0]       status_q;
	logic signed [VAL_W-1:0] found_value_q;
	logic [POS_W-1:0]        found_index_q;
	logic [POS_W-1:0]        entry_count_q;

	status_t                 res_status;
	logic signed [VAL_W-1:0] res_value;
	logic [POS_W-1:0]        res_index;

	// ---------------------------------------------------------------
	// Request capture: range checks use the count as it stands at accept
	// ---------------------------------------------------------------
	assign accept   = req.valid && req.ready;
	assign pos_x    = CMP_W'(req.position);
	assign cnt_x    = CMP_W'(count_q);
	assign cnt_wide = XW'(count_q);

	always_comb begin
		req_new            = '0;
		req_new.op         = req.op;
		req_new.position   = req.position;
		req_new.item_value = req.item_value;
		req_new.count_lo   = cnt_wide[POS_W-1:0];
		if (op_t'(req.op) == OP_INSERT)
			req_new.rng_ok = (pos_x <= cnt_x) && (count_q < CNT_W'(CAPACITY));
		else
			req_new.rng_ok = pos_x < cnt_x;
		req_new.do_ins = (op_t'(req.op) == OP_INSERT) && req_new.rng_ok;
		req_new.do_del = (op_t'(req.op) == OP_DELETE) && req_new.rng_ok;
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_q <= req_new;
	end

	// ---------------------------------------------------------------
	// Sequencer: IDLE -> EVAL (cells shift, hits latched) -> TREE
	// (one level per cycle) -> DONE (load output register)
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		req.ready = 1'b0;
		eval      = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid)
					state_nxt = S_EVAL;
			end
			S_EVAL: begin
				eval      = 1'b1;
				state_nxt = S_TREE;
			end
			S_TREE: begin
				if (tree_cnt_q == TC_W'(LEVELS - 1))
					state_nxt = S_DONE;
			end
			S_DONE: begin
				load_out = !rsp_valid_q || rsp.ready;
				if (load_out)
					state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tree_cnt_q <= '0;
		end else if (state_q == S_TREE) begin
			tree_cnt_q <= tree_cnt_q + TC_W'(1);
		end else begin
			tree_cnt_q <= '0;
		end
	end

	// entry count moves on the same edge the cells shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (eval && req_q.do_ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (eval && req_q.do_del) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// ---------------------------------------------------------------
	// Cell chain; each cell sees its lower and upper neighbor
	// ---------------------------------------------------------------
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		iol_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.req        (req_q),
			.count      (count_q),
			.eval       (eval),
			.left_word  (cell_word[(i == 0) ? 0 : i - 1]),
			.right_word (cell_word[(i == CAPACITY - 1) ? i : i + 1]),
			.word       (cell_word[i]),
			.hit_s1     (leaf_hit[i]),
			.data_s1    (leaf_data[i])
		);
	end

	iol_tree #(
		.LEAVES (CAPACITY),
		.IDX_W  (IDX_W)
	) u_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.leaf_hit  (leaf_hit),
		.leaf_data (leaf_data),
		.root_hit  (root_hit),
		.root_idx  (root_idx),
		.root_data (root_data)
	);

	// ---------------------------------------------------------------
	// Result assembly from the tree root and the captured request
	// ---------------------------------------------------------------
	assign idx_wide = XW'(root_idx);

	always_comb begin
		res_status = ST_RANGE;
		res_value  = '0;
		res_index  = '0;
		case (op_t'(req_q.op))
			OP_INSERT: begin
				if (req_q.rng_ok) begin
					res_status = ST_OK;
					res_index  = req_q.position;
				end
			end
			OP_DELETE, OP_READ: begin
				if (req_q.rng_ok) begin
					res_status = ST_OK;
					res_value  = root_data;
					res_index  = req_q.position;
				end
			end
			OP_FIND: begin
				res_status = ST_NOTFOUND;
				if (root_hit) begin
					res_status = ST_OK;
					res_index  = idx_wide[POS_W-1:0];
				end
			end
			OP_LBOUND: begin
				// no entry at or above the value: insertion point is the end
				res_status = ST_OK;
				res_index  = root_hit ? idx_wide[POS_W-1:0] : req_q.count_lo;
			end
			default: res_status = ST_RANGE;
		endcase
	end

	// output register: holds a finished beat while the next request runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q      <= res_status;
			found_value_q <= res_value;
			found_index_q <= res_index;
			entry_count_q <= cnt_wide[POS_W-1:0];
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.found_value = found_value_q;
	assign rsp.found_index = found_index_q;
	assign rsp.entry_count = entry_count_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EVAL)
		else $error("accepted request did not reach evaluation");

	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(state_q == S_EVAL))
		else $error("count changed outside evaluation");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("response raised without a finished request");

	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(eval && req_q.do_ins) |-> count_q < CNT_W'(CAPACITY))
		else $error("insert into full list");

endmodule

@@ verif/list_checker.sv @@
// Scoreboard for the indexed ordered list core: keeps its own copy of the list,
// predicts one response per accepted request beat and checks responses in order.
// Depends on iol_pkg and the iol_req_if / iol_rsp_if interfaces.
module list_checker import iol_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	iol_req_if   req,
	iol_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [STAT_W-1:0]       status;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        index;
		logic [POS_W-1:0]        count;
	} list_rsp_t;

	logic signed [VAL_W-1:0] words [CAPACITY];
	int                      used;
	list_rsp_t               rsp_pending [$];

	// applies one request to the shadow list and returns the response it owes
	function automatic list_rsp_t apply_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
			logic signed [VAL_W-1:0] val);
		list_rsp_t r;
		int        p;
		r.status = ST_RANGE;
		r.value  = '0;
		r.index  = '0;
		p = int'(pos);
		case (op)
			OP_INSERT: begin
				if (p <= used && used < CAPACITY) begin
					for (int i = used; i > p; i--)
						words[i] = words[i - 1];
					words[p] = val;
					used++;
					r.status = ST_OK;
					r.index  = pos;
				end
			end
			OP_DELETE: begin
				if (p < used) begin
					r.value = words[p];
					for (int i = p; i + 1 < used; i++)
						words[i] = words[i + 1];
					used--;
					r.status = ST_OK;
					r.index  = pos;
				end
			end
			OP_READ: begin
				if (p < used) begin
					r.value  = words[p];
					r.status = ST_OK;
					r.index  = pos;
				end
			end
			OP_FIND: begin
				r.status = ST_NOTFOUND;
				for (int i = 0; i < used && r.status != ST_OK; i++) begin
					if (words[i] == val) begin
						r.status = ST_OK;
						r.index  = i[POS_W-1:0];
					end
				end
			end
			OP_LBOUND: begin
				p = 0;
				while (p < used && words[p] < val)
					p++;
				r.status = ST_OK;
				r.index  = p[POS_W-1:0];
			end
			default: ;
		endcase
		r.count = used[POS_W-1:0];
		return r;
	endfunction

	function automatic int field_diff(string name, logic signed [31:0] want,
			logic signed [31:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_rsp_t want;
		int        errs;
		if (!arst_n) begin
			used = 0;
			rsp_pending.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			errs = 0;
			if (req.valid && req.ready)
				rsp_pending.push_back(apply_request(req.op, req.position, req.item_value));
			if (rsp.valid && rsp.ready) begin
				if (rsp_pending.size() == 0) begin
					$display("%0t: response beat with none expected, got status %0d index %0d",
						$time, rsp.status, rsp.found_index);
					errs = 1;
				end else begin
					want = rsp_pending.pop_front();
					errs = field_diff("status", 32'(want.status), 32'(rsp.status))
						+ field_diff("found_value", want.value, rsp.found_value)
						+ field_diff("found_index", 32'(want.index), 32'(rsp.found_index))
						+ field_diff("entry_count", 32'(want.count), 32'(rsp.entry_count));
				end
			end
			fail_count <= fail_count + errs;
			pending    <= rsp_pending.size();
		end
	end

endmodule

@@ verif/testbench.sv @@
// Top of the indexed ordered list testbench: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict. Depends on iol_pkg, the channel
// interfaces, indexed_ordered_list_core and list_checker.
module testbench import iol_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY   = DEF_CAPACITY;
	localparam int LATENCY    = $clog2(CAPACITY) + 3;
	// longest legal quiet spell is a long gap or stall plus one request
	// latency; this is many times that
	localparam int IDLE_LIMIT = 4000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   list_len = 0;   // shadow length, used to aim positions and to end the fill and drain loops
	bit   quiet    = 1'b0; // no gaps and no new stalls while set

	iol_req_if req ();
	iol_rsp_if rsp ();

	indexed_ordered_list_core #(.CAPACITY(CAPACITY)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	list_checker #(.CAPACITY(CAPACITY)) scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 70)
			return 0;
		if (roll < 96)
			return $urandom_range(1, 3);
		return $urandom_range(20, 80);
	endfunction

	// small pool so finds hit and duplicates show up, plus the extremes
	function automatic logic signed [VAL_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return VAL_W'(int'($urandom_range(0, 6)) - 3);
		if (roll < 50) begin
			case ($urandom_range(0, 3))
				0:       return {1'b0, {(VAL_W-1){1'b1}}};
				1:       return {1'b1, {(VAL_W-1){1'b0}}};
				2:       return '1;
				default: return '0;
			endcase
		end
		return $urandom;
	endfunction

	// one request beat; called and returns at a falling edge. valid stays high
	// across back-to-back beats so it is never lowered and raised in one step.
	task automatic send(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
			logic signed [VAL_W-1:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid      <= 1'b1;
		req.op         <= op;
		req.position   <= pos;
		req.item_value <= val;
		do
			@(posedge clk);
		while (!req.ready);
		@(negedge clk);
		case (op)
			OP_INSERT: if (pos <= list_len && list_len < CAPACITY) list_len++;
			OP_DELETE: if (pos < list_len) list_len--;
			default: ;
		endcase
	endtask

	// random beat with a given insert/delete mix; positions mostly in range
	task automatic random_beat(int ins_pct, int del_pct);
		int                      roll;
		logic [OP_W-1:0]         op;
		logic [POS_W-1:0]        pos;
		roll = $urandom_range(0, 99);
		if (roll < ins_pct)
			op = OP_INSERT;
		else if (roll < ins_pct + del_pct)
			op = OP_DELETE;
		else if (roll < 95) begin
			case ($urandom_range(0, 2))
				0:       op = OP_READ;
				1:       op = OP_FIND;
				default: op = OP_LBOUND;
			endcase
		end else
			op = OP_W'($urandom_range(int'(OP_LBOUND) + 1, (1 << OP_W) - 1));
		if ($urandom_range(0, 99) < 15)
			pos = POS_W'($urandom);
		else if (op == OP_INSERT)
			pos = POS_W'($urandom_range(0, list_len));
		else
			pos = (list_len > 0) ? POS_W'($urandom_range(0, list_len - 1)) : '0;
		send(op, pos, pick_value());
	endtask

	// response side: ready mostly high, short stalls, now and then a long one
	initial begin
		int stall;
		stall = 0;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall == 0 && !quiet && $urandom_range(0, 99) < 20)
				stall = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
					: $urandom_range(1, 3);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				stall--;
			end else
				rsp.ready <= 1'b1;
		end
	end

	// watchdog: ends the run after too many cycles with no beat on either side
	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle = 0;
			else
				idle++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		req.valid      = 1'b0;
		req.op         = OP_INSERT;
		req.position   = '0;
		req.item_value = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list: find misses, lower bound is 0, delete/read/insert past end fail
		send(OP_FIND, '0, '0);
		send(OP_LBOUND, '0, 32'sd17);
		send(OP_DELETE, '0, '0);
		send(OP_READ, '0, '0);
		send(OP_INSERT, 9'd1, 32'sd9);
		// extremes at the front, append at the end, then an insert far past it
		send(OP_INSERT, '0, 32'sh7fffffff);
		send(OP_INSERT, '0, 32'sh80000000);
		send(OP_INSERT, 9'd2, 32'sd5);
		send(OP_INSERT, '1, 32'sd1);
		send(OP_READ, '0, '0);
		send(OP_READ, 9'd3, '0);
		send(OP_READ, 9'd256, '0);
		// last entry must be found; a missing value must not
		send(OP_FIND, '0, 32'sd5);
		send(OP_FIND, '0, 32'sd12345);
		// lower bound equal to the first entry gives 0
		send(OP_LBOUND, '0, 32'sh80000000);
		send(OP_DELETE, 9'd2, '0);
		send(OP_DELETE, 9'd1, '0);
		// above every entry gives count
		send(OP_LBOUND, '0, '0);
		// undefined op codes
		for (int c = int'(OP_LBOUND) + 1; c < (1 << OP_W); c++)
			send(OP_W'(c), POS_W'($urandom), $urandom);
		send(OP_DELETE, '0, '0);

		// fill to capacity with random positions, then poke the full list
		while (list_len < CAPACITY) begin
			quiet = (list_len >= CAPACITY / 2);
			send(OP_INSERT, POS_W'($urandom_range(0, list_len)), pick_value());
		end
		quiet = 1'b0;
		send(OP_INSERT, '0, 32'sd3);
		send(OP_INSERT, 9'd256, 32'sd3);
		send(OP_READ, 9'(CAPACITY - 1), '0);
		send(OP_READ, 9'd256, '0);
		send(OP_DELETE, 9'd256, '0);
		send(OP_LBOUND, '0, 32'sh7fffffff);

		// mixed traffic, alternating toward shrinking and growing
		for (int chunk = 0; chunk < 10; chunk++) begin
			quiet = ($urandom_range(0, 3) == 0);
			repeat (50) begin
				if (chunk % 2)
					random_beat(45, 15);
				else
					random_beat(15, 45);
			end
		end

		// drain to empty, then short mixed traffic on a small list
		quiet = 1'b0;
		while (list_len > 0)
			send(OP_DELETE, POS_W'($urandom_range(0, list_len - 1)), pick_value());
		send(OP_READ, '0, '0);
		send(OP_FIND, '0, '0);
		repeat (100)
			random_beat(40, 25);

		req.valid <= 1'b0;
		wait (pending == 0);
		repeat (4 * LATENCY) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
